/* design/rgbpwd_pkg.sv */
// ----------------------------------------------------------------------------
// rgbpwd_pkg
// Shared types and constants for the single-wire RGB pixel chain driver:
// command codes, waveform phases, register indexes and the result record.
// ----------------------------------------------------------------------------
package rgbpwd_pkg;

    // Command codes carried by each input transfer
    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_START  = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    // Waveform sequencer phases
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2,
        PH_LATCH = 2'd3
    } t_phase;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_ONE_HIGH  = 2'd0,
        REG_ZERO_HIGH = 2'd1,
        REG_LOW       = 2'd2,
        REG_LATCH     = 2'd3
    } t_cfg_reg;

    // Field widths
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned BIT_TICK_W  = 8;
    localparam int unsigned PHASE_CNT_W = 16;
    localparam int unsigned PIXEL_W     = 24;
    localparam int unsigned COLOR_W     = 8;
    localparam int unsigned PIX_IDX_W   = 3;
    localparam int unsigned BIT_IDX_W   = 5;

    // Last bit of a pixel (blue LSB) and the largest addressable store depth
    localparam logic [BIT_IDX_W-1:0] LAST_BIT     = 5'd23;
    localparam int unsigned          STORE_MAX    = 8;

    // Register reset values
    localparam logic [BIT_TICK_W-1:0]  ONE_HIGH_RST  = 8'd46;
    localparam logic [BIT_TICK_W-1:0]  ZERO_HIGH_RST = 8'd20;
    localparam logic [BIT_TICK_W-1:0]  LOW_RST       = 8'd50;
    localparam logic [PHASE_CNT_W-1:0] LATCH_RST     = 16'd4000;

    // One result item
    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic accepted;
    } t_result;

endpackage

/* design/rgbpwd_out_buf.sv */
// ----------------------------------------------------------------------------
// rgbpwd_out_buf
// Two-entry result buffer: a head register that drives the output channel
// and a skid register that catches one more result while the head stalls.
// ----------------------------------------------------------------------------
module rgbpwd_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rgbpwd_pkg::t_result i_data,
    output logic                o_space,
    output logic                o_valid,
    input  logic                i_ready,
    output rgbpwd_pkg::t_result o_data
);

    logic                r_head_valid;
    logic                r_skid_valid;
    rgbpwd_pkg::t_result r_head;
    rgbpwd_pkg::t_result r_skid;
    logic                n_head_valid;
    logic                n_skid_valid;
    rgbpwd_pkg::t_result n_head;
    rgbpwd_pkg::t_result n_skid;
    logic                w_pop;

    assign w_pop   = r_head_valid & i_ready;
    assign o_space = ~r_skid_valid;
    assign o_valid = r_head_valid;
    assign o_data  = r_head;

    // Advance the head from the skid entry or take the new result
    always_comb begin
        n_head_valid = r_head_valid;
        n_skid_valid = r_skid_valid;
        n_head       = r_head;
        n_skid       = r_skid;
        if (w_pop) begin
            if (r_skid_valid) begin
                n_head       = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_head_valid = i_push;
                n_head       = i_data;
            end
        end else if (i_push) begin
            if (!r_head_valid) begin
                n_head_valid = 1'b1;
                n_head       = i_data;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = i_data;
            end
        end
    end

    // Hold valid flags under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_head_valid <= n_head_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_skid <= n_skid;
    end

endmodule

/* design/rgb_pixel_chain_waveform_driver_core.sv */
// A result is registered in the result buffer before it is valid on the output.
// Throughput: one command per cycle; the two-entry result buffer keeps input
// ready while one result waits, so only a stall of two results blocks input.
// Each tick command advances the waveform by one time unit in that cycle.
// Reset (synchronous, active low): sequencer idle, pixel store cleared to zero,
// timing registers back to their defaults, result buffer empty.
// ----------------------------------------------------------------------------
// rgb_pixel_chain_waveform_driver_core
// Single-wire serial driver for a chain of RGB pixels: holds the pixel colors
// and plays them out green, red, blue, MSB first, as high/low pulse pairs
// followed by a latch gap unless its length is zero, one time unit per tick command.
// ----------------------------------------------------------------------------
module rgb_pixel_chain_waveform_driver_core #(
    parameter int unsigned PIXEL_COUNT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [2:0]  i_pixel_index,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_blue,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_line_level,
    output logic        o_busy_res,
    output logic        o_accepted,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // Only pixel indexes below PIXEL_COUNT and below eight can be written; pixels beyond the store read zero
    localparam int unsigned STORE_DEPTH =
        (PIXEL_COUNT < rgbpwd_pkg::STORE_MAX) ? PIXEL_COUNT : rgbpwd_pkg::STORE_MAX;
    localparam int unsigned STORE_IW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int unsigned PIX_W    = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

    localparam int unsigned BT_W = rgbpwd_pkg::BIT_TICK_W;
    localparam int unsigned PC_W = rgbpwd_pkg::PHASE_CNT_W;
    localparam int unsigned PX_W = rgbpwd_pkg::PIXEL_W;
    localparam int unsigned BI_W = rgbpwd_pkg::BIT_IDX_W;

    // Timing registers
    logic [BT_W-1:0] r_one_high;
    logic [BT_W-1:0] r_zero_high;
    logic [BT_W-1:0] r_low;
    logic [PC_W-1:0] r_latch;

    // Sequencer state and pixel store
    rgbpwd_pkg::t_phase r_phase;
    rgbpwd_pkg::t_phase n_phase;
    logic [PIX_W-1:0]   r_cur_pixel;
    logic [PIX_W-1:0]   n_cur_pixel;
    logic [BI_W-1:0]    r_cur_bit;
    logic [BI_W-1:0]    n_cur_bit;
    logic [PC_W-1:0]    r_ticks;
    logic [PC_W-1:0]    n_ticks;
    logic [PX_W-1:0]    r_pixel_store [STORE_DEPTH];

    rgbpwd_pkg::t_cmd    w_cmd;
    rgbpwd_pkg::t_phase  w_out_phase;
    rgbpwd_pkg::t_result w_result;
    logic                w_in_xfer;
    logic                w_space;
    logic                w_idle;
    logic                w_write_ok;
    logic                w_start_ok;
    logic [PX_W-1:0]     w_cur_px;
    logic                w_cur_bit_val;
    logic [PC_W-1:0]     w_phase_len;
    logic [PC_W:0]       w_ticks_inc;
    logic                w_last_pixel;
    logic [BI_W-1:0]     w_bit_pos;

    assign w_cmd       = rgbpwd_pkg::t_cmd'(i_command);
    assign o_in_ready  = w_space;
    assign w_in_xfer   = i_in_valid & w_space;
    assign o_cfg_ready = 1'b1;
    assign w_idle      = (r_phase == rgbpwd_pkg::PH_IDLE);
    assign w_write_ok  = w_idle && (w_cmd == rgbpwd_pkg::CMD_WRITE)
                         && (32'(i_pixel_index) < PIXEL_COUNT);
    assign w_start_ok  = w_idle && (w_cmd == rgbpwd_pkg::CMD_START);

    // Fetch the bit under transmission
    always_comb begin
        if (32'(r_cur_pixel) < STORE_DEPTH) begin
            w_cur_px = r_pixel_store[r_cur_pixel[STORE_IW-1:0]];
        end else begin
            w_cur_px = '0;
        end
    end
    assign w_bit_pos     = rgbpwd_pkg::LAST_BIT - r_cur_bit;
    assign w_cur_bit_val = w_cur_px[w_bit_pos];
    assign w_last_pixel  = !((32'(r_cur_pixel) + 32'd1) < PIXEL_COUNT);

    // Select the length of the current phase
    always_comb begin
        unique case (r_phase)
            rgbpwd_pkg::PH_HIGH:  w_phase_len = PC_W'(w_cur_bit_val ? r_one_high
                                                                    : r_zero_high);
            rgbpwd_pkg::PH_LOW:   w_phase_len = PC_W'(r_low);
            rgbpwd_pkg::PH_LATCH: w_phase_len = r_latch;
            default:              w_phase_len = '0;
        endcase
    end
    assign w_ticks_inc = {1'b0, r_ticks} + (PC_W + 1)'(1);

    // Next state of the sequencer
    always_comb begin
        n_phase     = r_phase;
        n_cur_pixel = r_cur_pixel;
        n_cur_bit   = r_cur_bit;
        n_ticks     = r_ticks;
        if (w_in_xfer) begin
            unique case (w_cmd)
                rgbpwd_pkg::CMD_TICK: begin
                    if (!w_idle) begin
                        if (w_ticks_inc < {1'b0, w_phase_len}) begin
                            n_ticks = w_ticks_inc[PC_W-1:0];
                        end else begin
                            n_ticks = '0;
                            unique case (r_phase)
                                rgbpwd_pkg::PH_HIGH: n_phase = rgbpwd_pkg::PH_LOW;
                                rgbpwd_pkg::PH_LOW: begin
                                    priority if (r_cur_bit < rgbpwd_pkg::LAST_BIT) begin
                                        n_cur_bit = r_cur_bit + BI_W'(1);
                                        n_phase   = rgbpwd_pkg::PH_HIGH;
                                    end else if (!w_last_pixel) begin
                                        n_cur_bit   = '0;
                                        n_cur_pixel = r_cur_pixel + PIX_W'(1);
                                        n_phase     = rgbpwd_pkg::PH_HIGH;
                                    end else begin
                                        n_cur_bit   = '0;
                                        n_cur_pixel = '0;
                                        n_phase     = (r_latch == '0)
                                                      ? rgbpwd_pkg::PH_IDLE
                                                      : rgbpwd_pkg::PH_LATCH;
                                    end
                                end
                                default: n_phase = rgbpwd_pkg::PH_IDLE;
                            endcase
                        end
                    end
                end
                rgbpwd_pkg::CMD_START: begin
                    if (w_start_ok) begin
                        n_phase     = rgbpwd_pkg::PH_HIGH;
                        n_cur_pixel = '0;
                        n_cur_bit   = '0;
                        n_ticks     = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Result: a tick reports the state before it, other commands the state after
    always_comb begin
        w_out_phase         = (w_cmd == rgbpwd_pkg::CMD_TICK) ? r_phase : n_phase;
        w_result.line_level = (w_out_phase == rgbpwd_pkg::PH_HIGH);
        w_result.busy_res   = (w_out_phase != rgbpwd_pkg::PH_IDLE);
        w_result.accepted   = w_write_ok | w_start_ok;
    end

    // Advance sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= rgbpwd_pkg::PH_IDLE;
            r_cur_pixel <= '0;
            r_cur_bit   <= '0;
            r_ticks     <= '0;
        end else begin
            r_phase     <= n_phase;
            r_cur_pixel <= n_cur_pixel;
            r_cur_bit   <= n_cur_bit;
            r_ticks     <= n_ticks;
        end
    end

    // Write the pixel store; reset clears it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                r_pixel_store[i] <= '0;
            end
        end else if (w_in_xfer && w_write_ok) begin
            r_pixel_store[i_pixel_index[STORE_IW-1:0]] <= {i_green, i_red, i_blue};
        end
    end

    // Take configuration transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_high  <= rgbpwd_pkg::ONE_HIGH_RST;
            r_zero_high <= rgbpwd_pkg::ZERO_HIGH_RST;
            r_low       <= rgbpwd_pkg::LOW_RST;
            r_latch     <= rgbpwd_pkg::LATCH_RST;
        end else if (i_cfg_valid) begin
            unique case (rgbpwd_pkg::t_cfg_reg'(i_cfg_index))
                rgbpwd_pkg::REG_ONE_HIGH:  r_one_high  <= i_cfg_data[BT_W-1:0];
                rgbpwd_pkg::REG_ZERO_HIGH: r_zero_high <= i_cfg_data[BT_W-1:0];
                rgbpwd_pkg::REG_LOW:       r_low       <= i_cfg_data[BT_W-1:0];
                default:                   r_latch     <= i_cfg_data;
            endcase
        end
    end

    // Buffer results toward the output channel
    rgbpwd_pkg::t_result w_out_data;

    rgbpwd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_in_xfer),
        .i_data  (w_result),
        .o_space (w_space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (w_out_data)
    );

    assign o_line_level = w_out_data.line_level;
    assign o_busy_res   = w_out_data.busy_res;
    assign o_accepted   = w_out_data.accepted;

endmodule

/* design/rgbpwd_checker.sv */
// ----------------------------------------------------------------------------
// rgbpwd_checker
// Port-level checks for the pixel chain driver, bound to the top level.
// ----------------------------------------------------------------------------
module rgbpwd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_line_level,
    input logic        o_busy_res,
    input logic        o_accepted
);

    // The output buffer is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A high line level only occurs inside a frame
    a_level_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_level |-> o_busy_res)
        else $error("line high while not busy");

    // An accepted start leaves the line in the high part of the first bit
    a_start_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_accepted && o_busy_res |-> o_line_level)
        else $error("accepted start without high level");

    // Every input transfer yields a waiting result in the next cycle
    a_xfer_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("input transfer produced no result");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_line_level)
            && $stable(o_busy_res) && $stable(o_accepted))
        else $error("stalled result changed");

endmodule

bind rgb_pixel_chain_waveform_driver_core rgbpwd_checker u_rgbpwd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_line_level (o_line_level),
    .o_busy_res   (o_busy_res),
    .o_accepted   (o_accepted)
);
